@@ hw/rtl/rbftx_pkg.sv @@
// Shared constants, types and helper functions for the byte filter and UART transmitter.
// This package has no dependencies. rbftx_fifo, the top level and the testbench use it.
`default_nettype none

package rbftx_pkg;

	// Receive queue geometry.
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Reset value of the indicator on-time register.
	localparam logic [7:0] LED_TICKS_RST = 8'd32;

	// Bytes that are dropped instead of sent, compared after the bit reversal.
	localparam logic [7:0] BLK_BYTE_A = 8'hFA;
	localparam logic [7:0] BLK_BYTE_B = 8'hFB;
	localparam logic [7:0] BLK_BYTE_C = 8'hFC;

	// Queue status seen by the control logic.
	typedef struct packed {
		logic full;
		logic nonempty;
	} fifo_stat_t;

	// Reverses the bit order of a byte with three swap stages.
	function automatic logic [7:0] mirror8(input logic [7:0] v);
		logic [7:0] x;
		x = ((v >> 1) & 8'h55) | ((v << 1) & 8'hAA);
		x = ((x >> 2) & 8'h33) | ((x << 2) & 8'hCC);
		x = ((x >> 4) & 8'h0F) | ((x << 4) & 8'hF0);
		return x;
	endfunction

	function automatic logic is_blocked(input logic [7:0] b);
		return (b == BLK_BYTE_A) || (b == BLK_BYTE_B) || (b == BLK_BYTE_C);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rbftx_fifo.sv @@
// Receive byte queue. It holds a memory with a registered read that always presents the oldest byte.
// It depends on rbftx_pkg for the depth, the widths and the status struct.
`default_nettype none

module rbftx_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [7:0]             push_data,
	input  wire logic                   pop,
	output logic [7:0]                  front_data,
	output rbftx_pkg::fifo_stat_t       stat
);

	logic [7:0]                      mem [rbftx_pkg::FIFO_DEPTH];
	logic [rbftx_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [rbftx_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [rbftx_pkg::FIFO_AW-1:0]   rd_ptr_d;
	logic [rbftx_pkg::FIFO_CW-1:0]   count_q;
	logic [7:0]                      rdata_q;

	function automatic logic [rbftx_pkg::FIFO_AW-1:0] ptr_next(
		input logic [rbftx_pkg::FIFO_AW-1:0] p);
		return (p == rbftx_pkg::FIFO_AW'(rbftx_pkg::FIFO_DEPTH - 1)) ?
			'0 : p + 1'b1;
	endfunction

	assign rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
				count_q  <= count_q + 1'b1;
			end else if (pop) begin
				count_q  <= count_q - 1'b1;
			end
		end
	end

	// The read register follows the next read pointer, so it always mirrors the
	// entry at the current read pointer. A write to that same entry is forwarded.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (push && (wr_ptr_q == rd_ptr_d)) begin
			rdata_q <= push_data;
		end else begin
			rdata_q <= mem[rd_ptr_d];
		end
	end

	assign front_data    = rdata_q;
	assign stat.full     = (count_q == rbftx_pkg::FIFO_CW'(rbftx_pkg::FIFO_DEPTH));
	assign stat.nonempty = (count_q != '0);

endmodule

`default_nettype wire

@@ hw/rtl/realtime_byte_filter_uart_tx.sv @@
// Top level of the byte filter with 8N1 transmitter: stream ports, control and indicators.
// It depends on rbftx_pkg and instantiates rbftx_fifo for the receive queue.
//
// Channel  | Direction | Signals                         | Contents
// ---------+-----------+---------------------------------+-----------------------------------
// s_       | in        | s_tvalid s_tready s_tdata s_tuser | tdata: rx_byte; tuser: opcode
// m_       | out       | m_tvalid m_tready m_tdata        | tdata: line, send, block, ovf, busy
// cfg_     | in        | cfg_valid cfg_ready cfg_data     | led_pulse_ticks
//
// An accepted item is held in the input register. It is then worked on in a single pass
// and lands in the result register once that register is free or being emptied, and its
// result is presented from the result register.
// A new item can enter on every cycle. The throughput is one item per clock, and only the
// readiness of the result sink slows it down.
// Reset is asynchronous and active low. It empties the queue, idles the line high and
// clears both indicators. The on-time register returns to 32 ticks.
// When the result register is full and not being taken, the input register holds its
// item and s_tready drops in the same cycle.
`default_nettype none

module realtime_byte_filter_uart_tx (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Input items.
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	input  wire logic       s_tuser,   // [0] opcode: 0 byte arrives, 1 bit tick
	// Result items.
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [0] tx_line [1] send_indicator [2] block_indicator
	                                   // [3] fifo_overflow [4] tx_busy [7:5] zero
	// Configuration write.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data   // led_pulse_ticks
);

	// Transmit phase codes: the value names the bit that the next tick drives.
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_DATA0 = 4'd2;
	localparam logic [3:0] PH_STOP  = 4'd10;

	// Input register.
	logic                  s1_v_s1;
	logic                  op_s1;
	logic [7:0]            byte_s1;
	logic                  advance;

	// Block state.
	logic [7:0]            led_ticks_q;
	logic [7:0]            shift_q,     shift_d;
	logic [3:0]            phase_q,     phase_d;
	logic                  line_q,      line_d;
	logic [7:0]            send_cnt_q,  send_cnt_d;
	logic [7:0]            block_cnt_q, block_cnt_d;
	logic                  send_lvl_q,  send_lvl_d;
	logic                  block_lvl_q, block_lvl_d;
	logic                  frame_q,     frame_d;
	logic                  ovf;

	// Result register.
	logic                  m_v_q;
	logic [7:0]            m_data_q;

	// Queue interface.
	logic                  fifo_push;
	logic                  fifo_pop;
	logic [7:0]            fifo_front;
	rbftx_pkg::fifo_stat_t fifo_stat;

	logic [7:0]            popped;
	logic [2:0]            bit_idx;

	// The input register moves on whenever the result register is free or being emptied.
	assign advance   = s1_v_s1 && (!m_v_q || m_tready);
	assign s_tready  = !s1_v_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	rbftx_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fifo_push),
		.push_data  (byte_s1),
		.pop        (fifo_pop),
		.front_data (fifo_front),
		.stat       (fifo_stat)
	);

	assign popped  = rbftx_pkg::mirror8(fifo_front);
	assign bit_idx = 3'(phase_q - PH_DATA0);

	// Single-pass step. A byte arrival only touches the queue, or flags an overflow when full.
	// A tick ages the indicators, then may pop one byte, and drives one frame bit unless filtered.
	always_comb begin
		fifo_push   = 1'b0;
		fifo_pop    = 1'b0;
		ovf         = 1'b0;
		shift_d     = shift_q;
		phase_d     = phase_q;
		line_d      = line_q;
		send_cnt_d  = send_cnt_q;
		block_cnt_d = block_cnt_q;
		send_lvl_d  = send_lvl_q;
		block_lvl_d = block_lvl_q;
		frame_d     = frame_q;
		if (advance) begin
			if (!op_s1) begin
				if (fifo_stat.full) begin
					ovf = 1'b1;
				end else begin
					fifo_push = 1'b1;
				end
			end else begin
				send_lvl_d  = (send_cnt_q != '0);
				send_cnt_d  = send_cnt_q - {7'd0, send_lvl_d};
				block_lvl_d = (block_cnt_q != '0);
				block_cnt_d = block_cnt_q - {7'd0, block_lvl_d};
				if ((phase_q == PH_IDLE || phase_q > PH_STOP) && fifo_stat.nonempty) begin
					fifo_pop = 1'b1;
					shift_d  = popped;
					if (rbftx_pkg::is_blocked(popped)) begin
						// A filtered byte is discarded. The line stays idle and no frame starts.
						block_cnt_d = led_ticks_q;
						frame_d     = 1'b0;
						phase_d     = PH_IDLE;
					end else begin
						send_cnt_d = led_ticks_q;
						line_d     = 1'b0;
						phase_d    = PH_DATA0;
						frame_d    = 1'b1;
					end
				end else if (phase_q == PH_IDLE || phase_q > PH_STOP) begin
					line_d  = 1'b1;
					phase_d = PH_IDLE;
					frame_d = 1'b0;
				end else if (phase_q == PH_STOP) begin
					line_d  = 1'b1;
					phase_d = PH_IDLE;
					frame_d = 1'b1;
				end else if (phase_q == PH_START) begin
					line_d  = 1'b0;
					phase_d = PH_DATA0;
					frame_d = 1'b1;
				end else begin
					line_d  = shift_q[bit_idx];
					phase_d = phase_q + 1'b1;
					frame_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_ticks_q <= rbftx_pkg::LED_TICKS_RST;
			shift_q     <= '0;
			phase_q     <= PH_IDLE;
			line_q      <= 1'b1;
			send_cnt_q  <= '0;
			block_cnt_q <= '0;
			send_lvl_q  <= 1'b0;
			block_lvl_q <= 1'b0;
			frame_q     <= 1'b0;
			m_v_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				led_ticks_q <= cfg_data;
			end
			shift_q     <= shift_d;
			phase_q     <= phase_d;
			line_q      <= line_d;
			send_cnt_q  <= send_cnt_d;
			block_cnt_q <= block_cnt_d;
			send_lvl_q  <= send_lvl_d;
			block_lvl_q <= block_lvl_d;
			frame_q     <= frame_d;
			if (advance) begin
				m_v_q <= 1'b1;
			end else if (m_tready) begin
				m_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {3'd0, frame_d, ovf, block_lvl_d, send_lvl_d, line_d};
		end
	end

	assign m_tvalid = m_v_q;
	assign m_tdata  = m_data_q;

	// A pop is only issued when the queue holds a byte, and a push only when it has room.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> fifo_stat.nonempty)
		else $error("queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_stat.full)
		else $error("queue pushed while full");

	// The transmitter never reaches a phase code beyond the stop bit.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_STOP)
		else $error("transmit phase out of range");

	// A low line level is only ever reported inside a frame.
	a_low_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_v_q && !m_data_q[0]) |-> m_data_q[4])
		else $error("line low outside a frame");

endmodule

`default_nettype wire

@@ test/tb_realtime_byte_filter_uart_tx.sv @@
// Self-checking testbench for the byte filter with 8N1 transmitter.
// Depends on rbftx_pkg and realtime_byte_filter_uart_tx; predicts every status item
// from its own copy of the receive queue, transmitter phase and indicator counters.
`timescale 1ns / 100ps

module tb_realtime_byte_filter_uart_tx;

	// Item kinds carried on s_tuser.
	localparam logic OP_RX_BYTE  = 1'b0;
	localparam logic OP_BIT_TICK = 1'b1;

	// Transmitter phases: start bit next, data bits 0..7 next, stop bit next.
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_DATA0 = 4'd2;
	localparam logic [3:0] PH_STOP  = 4'd10;

	// Received bytes whose mirror image is one of the dropped values.
	localparam logic [7:0] RX_BLK_A = 8'h5F;
	localparam logic [7:0] RX_BLK_B = 8'hDF;
	localparam logic [7:0] RX_BLK_C = 8'h3F;

	// Random stimulus shape: kinds of segment and how many items each holds.
	localparam int SEG_BURST    = 0;
	localparam int SEG_DRAIN    = 1;
	localparam int SEG_BALANCED = 2;
	localparam int SEG_ITEMS    = 100;

	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	localparam int REPORT_LIMIT  = 10;

	// Status item as it appears on m_tdata, lowest bit last in the list.
	typedef struct packed {
		logic [2:0] pad;
		logic       busy;
		logic       ovf;
		logic       block;
		logic       send;
		logic       line;
	} line_status_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// Predicted transmitter state.
	logic [7:0]   rx_queue[$];
	logic [7:0]   pulse_ticks;
	logic [7:0]   frame_byte;
	logic [3:0]   tx_phase;
	logic         line_lvl;
	logic         busy_lvl;
	logic         send_lvl;
	logic         block_lvl;
	logic [7:0]   send_cnt;
	logic [7:0]   block_cnt;

	// Status items still owed by the block, oldest first.
	line_status_t status_queue[$];

	int  mismatches = 0;
	int  stall_cycles = 0;
	bit  idle_on = 1'b0;
	int  sink_gap = 0;
	int  sink_hold = 0;

	realtime_byte_filter_uart_tx dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap in cycles before the next item on either side. With idling switched off the
	// stream runs back to back.
	function automatic int draw_gap();
		return idle_on ? int'($urandom_range(0, 14)) : 0;
	endfunction

	// Advances the predicted state by one accepted item and returns the status it causes.
	function automatic line_status_t advance_filter(input logic op, input logic [7:0] data);
		line_status_t st;
		logic [7:0]   raw;
		logic [7:0]   mirrored;
		logic         dropped;
		st = '0;
		dropped = 1'b0;
		if (op == OP_RX_BYTE) begin
			if (rx_queue.size() >= rbftx_pkg::FIFO_DEPTH)
				st.ovf = 1'b1;
			else
				rx_queue.push_back(data);
		end else begin
			// The indicators show the counter as it stood before this tick.
			send_lvl  = (send_cnt != 8'd0);
			block_lvl = (block_cnt != 8'd0);
			if (send_cnt != 8'd0)
				send_cnt = send_cnt - 8'd1;
			if (block_cnt != 8'd0)
				block_cnt = block_cnt - 8'd1;
			if (tx_phase > PH_STOP)
				tx_phase = PH_IDLE;
			if (tx_phase == PH_IDLE && rx_queue.size() != 0) begin
				raw = rx_queue.pop_front();
				mirrored = {<<{raw}};
				frame_byte = mirrored;
				if (mirrored == rbftx_pkg::BLK_BYTE_A || mirrored == rbftx_pkg::BLK_BYTE_B ||
				    mirrored == rbftx_pkg::BLK_BYTE_C) begin
					// A filtered byte uses up the tick; the line stays idle.
					block_cnt = pulse_ticks;
					busy_lvl = 1'b0;
					dropped = 1'b1;
				end else begin
					send_cnt = pulse_ticks;
					tx_phase = PH_START;
				end
			end
			if (!dropped) begin
				if (tx_phase == PH_IDLE) begin
					line_lvl = 1'b1;
					busy_lvl = 1'b0;
				end else if (tx_phase == PH_STOP) begin
					line_lvl = 1'b1;
					tx_phase = PH_IDLE;
					busy_lvl = 1'b1;
				end else if (tx_phase == PH_START) begin
					line_lvl = 1'b0;
					tx_phase = PH_DATA0;
					busy_lvl = 1'b1;
				end else begin
					line_lvl = frame_byte[tx_phase - PH_DATA0];
					tx_phase = tx_phase + 4'd1;
					busy_lvl = 1'b1;
				end
			end
		end
		st.line  = line_lvl;
		st.send  = send_lvl;
		st.block = block_lvl;
		st.busy  = busy_lvl;
		return st;
	endfunction

	// Offers one item after a random gap and holds it until the block takes it. The valid
	// line is left high so that a following item without a gap goes out back to back.
	task automatic send_item(input logic op, input logic [7:0] data);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		status_queue.push_back(advance_filter(op, data));
	endtask

	task automatic send_tick();
		send_item(OP_BIT_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Random received byte; about one in five is a byte that the filter drops.
	task automatic send_random_byte();
		logic [7:0] b;
		case ($urandom_range(0, 14))
			0:       b = RX_BLK_A;
			1:       b = RX_BLK_B;
			2:       b = RX_BLK_C;
			default: b = 8'($urandom_range(0, 255));
		endcase
		send_item(OP_RX_BYTE, b);
	endtask

	// Lowers valid and waits until every owed status item has come back.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (status_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pulse_ticks(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		pulse_ticks = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Outputs right after reset, one full frame of an all-zero byte, and each of the three
	// dropped bytes, all with the on-time left at its reset value.
	task automatic test_directed();
		send_tick();
		send_item(OP_RX_BYTE, 8'h00);
		send_item(OP_RX_BYTE, RX_BLK_A);
		send_item(OP_RX_BYTE, RX_BLK_B);
		send_item(OP_RX_BYTE, RX_BLK_C);
		repeat (15) send_tick();
		wait_idle();
	endtask

	// Runs segments of random items under several on-time settings. Burst segments flood
	// the queue until it overflows, drain segments are nearly all ticks that pop bytes from it,
	// balanced ones mix in enough bytes to keep frames going.
	task automatic test_random_traffic();
		logic [7:0] settings[6];
		int         tick_pct;
		int         kind;
		settings[0] = 8'd0;
		settings[1] = 8'd255;
		settings[2] = 8'd1;
		settings[3] = 8'($urandom_range(0, 255));
		settings[4] = 8'($urandom_range(2, 20));
		settings[5] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 6; p++) begin
			write_pulse_ticks(settings[p]);
			for (int s = 0; s < 2; s++) begin
				kind = (2 * p + s) % 3;
				tick_pct = (kind == SEG_BURST) ? 5 : (kind == SEG_DRAIN) ? 97 : 91;
				idle_on = ($urandom_range(0, 2) != 0);
				for (int i = 0; i < SEG_ITEMS; i++) begin
					if ($urandom_range(0, 99) < tick_pct)
						send_tick();
					else
						send_random_byte();
				end
			end
			wait_idle();
		end
	endtask

	// The sink holds off for a long stretch while items keep coming, so the result and
	// input registers fill and s_tready has to drop.
	task automatic test_backpressure();
		idle_on = 1'b1;
		sink_hold = LONG_HOLD;
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_random_byte();
			else
				send_tick();
		end
		wait_idle();
	endtask

	// Result sink: random stalls between items, plus the long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compares each status item with the oldest prediction.
	always @(posedge clk) begin
		line_status_t got;
		line_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			sink_gap = draw_gap();
			if (status_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: status item %b arrived with none expected", $realtime,
					         got);
			end else begin
				want = status_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"%0t: status mismatch, expected line=%b send=%b ",
						          "block=%b ovf=%b busy=%b pad=%b, got line=%b send=%b ",
						          "block=%b ovf=%b busy=%b pad=%b"}, $realtime,
						         want.line, want.send, want.block, want.ovf, want.busy,
						         want.pad, got.line, got.send, got.block, got.ovf,
						         got.busy, got.pad);
				end
			end
		end
	end

	// Ends the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = OP_RX_BYTE;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;

		// Predicted state after reset.
		pulse_ticks = rbftx_pkg::LED_TICKS_RST;
		frame_byte  = 8'h00;
		tx_phase    = PH_IDLE;
		line_lvl    = 1'b1;
		busy_lvl    = 1'b0;
		send_lvl    = 1'b0;
		block_lvl   = 1'b0;
		send_cnt    = 8'd0;
		block_cnt   = 8'd0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic();
		test_backpressure();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && status_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
